FILE: rtl/rrts_pkg.sv
// rrts_pkg: shared types, codes and constants of the thread scheduler
// used by the scheduler top level and by its checker

package rrts_pkg;

  localparam int unsigned DefThreads   = 32;
  localparam int unsigned DefProcesses = 8;
  localparam int unsigned DefRxDepth   = 16;
  localparam int unsigned DefArgAlign  = 8;

  localparam int unsigned CfgW = 32;
  localparam int unsigned InW  = 48;  // tdata of the input beat, 46 bits padded
  localparam int unsigned OutW = 96;  // tdata of the output beat, 95 bits padded

  // register indexes
  localparam logic [1:0] RegStackTop  = 2'd0;
  localparam logic [1:0] RegStackSize = 2'd1;
  localparam logic [1:0] RegWaitTmo   = 2'd2;
  localparam logic [1:0] RegMaxThr    = 2'd3;

  typedef enum logic [1:0] {
    ActCreate = 2'd0,
    ActSwitch = 2'd1,
    ActTick   = 2'd2,
    ActPush   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    NsReady    = 2'd0,
    NsFinished = 2'd1,
    NsSleeping = 2'd2,
    NsWaitChar = 2'd3
  } new_state_e;

  typedef enum logic [2:0] {
    KndCreate  = 3'd0,
    KndSwitch  = 3'd1,
    KndByte    = 3'd2,
    KndTimeout = 3'd3,
    KndPushed  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoThread = 3'd1,
    StRdyFull  = 3'd2,
    StLimit    = 3'd3,
    StNoProc   = 3'd4,
    StBufFull  = 3'd5
  } status_e;

  localparam logic [1:0] ModeChild = 2'd0;
  localparam logic [1:0] ModeFork  = 2'd1;

  typedef enum logic [3:0] {
    SIdle,
    SCreate,
    SCreateMul,
    SCreateOut,
    SSwPark,
    SSwPop,
    SSwOut,
    SCwHead,
    SCwRead,
    SCwEval,
    SSlHead,
    SSlRead,
    SSlEval,
    SOut
  } state_e;

  // one result beat
  typedef struct packed {
    logic              last;
    logic [7:0]        data_byte;
    logic [31:0]       arg_pointer;
    logic [31:0]       stack_pointer;
    logic              context_change;
    logic signed [3:0] proc_id;
    logic signed [5:0] old_thread_id;
    logic signed [5:0] thread_id;
    logic [2:0]        status;
    logic [2:0]        kind;
  } result_t;

endpackage

FILE: rtl/rrts_fifo.sv
// rrts_fifo: small index queue with head pointer and fill count
// depends on nothing but its parameters; reset can preload 0..DEPTH-1

module rrts_fifo #(
  parameter int unsigned DEPTH   = 32,
  parameter int unsigned W       = 5,
  parameter bit          PRELOAD = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] head_q, head_d, tail;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign do_push = push_i && ((cnt_q != CW'(DEPTH)) || do_pop);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = CW'(a) + b;
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return AW'(s);
  endfunction

  assign tail    = wrap_add(head_q, cnt_q);
  assign head_o  = mem_q[head_q];
  assign count_o = cnt_q;

  // pointer and count update
  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (do_pop) head_d = wrap_add(head_q, CW'(1));
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= PRELOAD ? CW'(DEPTH) : '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, preloaded with its own index where asked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) mem_q[i] <= PRELOAD ? W'(i) : '0;
    end else if (do_push) begin
      mem_q[tail] <= push_data_i;
    end
  end
endmodule

FILE: rtl/rrts_mul.sv
// rrts_mul: registered 32x32 multiply used for the stack base offset
// no package dependencies

module rrts_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);
  logic [31:0] p_q;

  // low half of the product only
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

FILE: rtl/round_robin_thread_scheduler_top.sv
// round_robin_thread_scheduler_top: hardware thread scheduler
//
// Input channel s_axis_*: one beat is one command (create, switch, tick or
// received byte). Output channel m_axis_*: result beats, tlast on the final
// beat of a command. Configuration is a plain write port; the user must
// write it only while idle, the block does not enforce this. A command is
// taken only when the sequencer is idle; s_axis_tready is low until its
// last result beat has left. A tick visits each char-waiting thread and
// each sleeping thread; each visit pops the head, reads its countdown and
// evaluates it, and a delivery or timeout beat is loaded in the evaluate
// step, which waits only while the receiver stalls. Then it switches, with
// the running thread parked as ready. The per-thread countdown lives in a
// single-port memory with registered read, hence the separate read step.
// Reset empties all queues, puts every thread and process in its free queue
// in order, and leaves the running thread idle. When the receiver stalls
// a result beat is held in the output register and the sequencer waits before it loads another.

module round_robin_thread_scheduler_top #(
  parameter int unsigned THREADS   = rrts_pkg::DefThreads,
  parameter int unsigned PROCESSES = rrts_pkg::DefProcesses,
  parameter int unsigned RX_DEPTH  = rrts_pkg::DefRxDepth,
  parameter int unsigned ARG_ALIGN = rrts_pkg::DefArgAlign
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // action[1:0], create_mode[3:2], arg_bytes[19:4], new_state[21:20],
  // sleep_ticks[37:22], rx_byte[45:38]
  input  logic [rrts_pkg::InW-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // kind[2:0], status[5:3], thread_id[11:6], old_thread_id[17:12],
  // proc_id[21:18], context_change[22], stack_pointer[54:23],
  // arg_pointer[86:55], data_byte[94:87]
  output logic [rrts_pkg::OutW-1:0]    m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [rrts_pkg::CfgW-1:0]    cfg_data_i
);
  import rrts_pkg::*;

  localparam int unsigned TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned PW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned TCW = $clog2(THREADS+1);
  localparam int unsigned PCW = $clog2(PROCESSES+1);
  localparam int unsigned RCW = $clog2(RX_DEPTH+1);

  // ---------------- configuration registers
  logic [31:0] stack_top_q;
  logic [23:0] stack_bytes_q;
  logic [15:0] wait_tmo_q;
  logic [5:0]  max_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top_q   <= '0;
      stack_bytes_q <= 24'd16384;
      wait_tmo_q    <= 16'd40;
      max_thr_q     <= 6'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStackTop:  stack_top_q   <= cfg_data_i;
        RegStackSize: stack_bytes_q <= cfg_data_i[23:0];
        RegWaitTmo:   wait_tmo_q    <= cfg_data_i[15:0];
        RegMaxThr:    max_thr_q     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // ---------------- command fields
  logic [1:0]  act_q, mode_q, nst_q;
  logic [15:0] args_q, ticks_q;
  logic [7:0]  rxb_q;

  // ---------------- queues
  logic          rq_push, rq_pop, sq_push, sq_pop, cq_push, cq_pop;
  logic          fq_push, fq_pop, pq_push, pq_pop, bq_push, bq_pop;
  logic [TW-1:0] rq_din, rq_head, sq_din, sq_head, cq_din, cq_head;
  logic [TW-1:0] fq_din, fq_head;
  logic [PW-1:0] pq_din, pq_head;
  logic [7:0]    bq_head;
  logic [TCW-1:0] rq_cnt, sq_cnt, cq_cnt, fq_cnt;
  logic [PCW-1:0] pq_cnt;
  logic [RCW-1:0] bq_cnt;

  rrts_fifo #(.DEPTH(THREADS), .W(TW)) u_ready (
    .clk_i, .rst_ni, .push_i(rq_push), .push_data_i(rq_din), .pop_i(rq_pop),
    .head_o(rq_head), .count_o(rq_cnt));
  rrts_fifo #(.DEPTH(THREADS), .W(TW)) u_sleep (
    .clk_i, .rst_ni, .push_i(sq_push), .push_data_i(sq_din), .pop_i(sq_pop),
    .head_o(sq_head), .count_o(sq_cnt));
  rrts_fifo #(.DEPTH(THREADS), .W(TW)) u_cwait (
    .clk_i, .rst_ni, .push_i(cq_push), .push_data_i(cq_din), .pop_i(cq_pop),
    .head_o(cq_head), .count_o(cq_cnt));
  rrts_fifo #(.DEPTH(THREADS), .W(TW), .PRELOAD(1'b1)) u_fthr (
    .clk_i, .rst_ni, .push_i(fq_push), .push_data_i(fq_din), .pop_i(fq_pop),
    .head_o(fq_head), .count_o(fq_cnt));
  rrts_fifo #(.DEPTH(PROCESSES), .W(PW), .PRELOAD(1'b1)) u_fproc (
    .clk_i, .rst_ni, .push_i(pq_push), .push_data_i(pq_din), .pop_i(pq_pop),
    .head_o(pq_head), .count_o(pq_cnt));
  rrts_fifo #(.DEPTH(RX_DEPTH), .W(8)) u_rxbuf (
    .clk_i, .rst_ni, .push_i(bq_push), .push_data_i(rxb_q), .pop_i(bq_pop),
    .head_o(bq_head), .count_o(bq_cnt));

  // ---------------- thread table and process counts
  logic          tp_valid_q [THREADS];
  logic [PW-1:0] tp_q       [THREADS];
  logic [5:0]    pcnt_q     [PROCESSES];
  logic          run_valid_q;
  logic [TW-1:0] run_q;

  // countdown memory: one port, registered read, all zero after reset
  logic          cd_valid_q [THREADS];
  logic [31:0]   cd_mem     [THREADS];
  logic          cd_we, cd_re;
  logic [TW-1:0] cd_addr;
  logic [31:0]   cd_wdata, cd_rdata_q;
  logic          cd_rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cd_we) cd_mem[cd_addr] <= cd_wdata;
    if (cd_re) cd_rdata_q <= cd_mem[cd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREADS; i++) cd_valid_q[i] <= 1'b0;
      cd_rvalid_q <= 1'b0;
    end else begin
      if (cd_re) cd_rvalid_q <= cd_valid_q[cd_addr];
      if (cd_we) cd_valid_q[cd_addr] <= 1'b1;
    end
  end

  logic [31:0] cd_val;
  assign cd_val = cd_rvalid_q ? cd_rdata_q : 32'd0;

  // ---------------- shared multiplier, started with the process picked this cycle
  logic [31:0] mul_p;
  logic [PW-1:0] proc_q, proc_d;
  rrts_mul u_mul (
    .clk_i, .a_i({26'd0, pcnt_q[proc_d]}), .b_i({8'd0, stack_bytes_q}), .p_o(mul_p));

  // ---------------- sequencer registers
  state_e        st_q, st_d;
  logic [TCW-1:0] loop_q, loop_d;
  logic [TW-1:0] tid_q, tid_d;
  result_t       res_q, res_d;
  logic          ov_q, ov_d;
  logic signed [5:0] old_q, old_d;
  logic signed [3:0] oldp_q, oldp_d;

  // sequencer side effects as write strobes
  logic          tp_we, pc_we, run_we, run_vd;
  logic [TW-1:0] tp_idx, run_d;
  logic [PW-1:0] tp_val, pc_idx;
  logic [5:0]    pc_val;

  logic [31:0] ap, sp, pad;
  logic [$clog2(ARG_ALIGN+1)-1:0] rem;
  logic signed [3:0] run_pid;
  logic          out_free;

  localparam int unsigned AAW = $clog2(ARG_ALIGN+1);
  assign out_free = !ov_q || m_axis_tready;
  assign run_pid  = (run_valid_q && tp_valid_q[run_q]) ? 4'(signed'({1'b0, tp_q[run_q]}))
                                                       : -4'sd1;
  assign rem = AAW'(args_q % 16'(ARG_ALIGN));
  assign ap  = stack_top_q - mul_p - {16'd0, args_q};
  assign pad = (rem == '0) ? 32'd0 : 32'(ARG_ALIGN) - 32'(rem);
  assign sp  = ap - pad;

  function automatic result_t blank(kind_e k, status_e s);
    result_t r;
    r = '0;
    r.kind = k;
    r.status = s;
    r.thread_id = -6'sd1;
    r.old_thread_id = -6'sd1;
    r.proc_id = -4'sd1;
    r.last = 1'b1;
    return r;
  endfunction

  // ---------------- next state and control
  always_comb begin
    st_d = st_q; loop_d = loop_q; tid_d = tid_q; proc_d = proc_q;
    res_d = res_q; ov_d = ov_q; old_d = old_q; oldp_d = oldp_q;
    rq_push = 1'b0; rq_pop = 1'b0; rq_din = '0;
    sq_push = 1'b0; sq_pop = 1'b0; sq_din = '0;
    cq_push = 1'b0; cq_pop = 1'b0; cq_din = '0;
    fq_push = 1'b0; fq_pop = 1'b0; fq_din = '0;
    pq_push = 1'b0; pq_pop = 1'b0; pq_din = '0;
    bq_push = 1'b0; bq_pop = 1'b0;
    cd_we = 1'b0; cd_re = 1'b0; cd_addr = '0; cd_wdata = '0;
    tp_we = 1'b0; tp_idx = '0; tp_val = '0;
    pc_we = 1'b0; pc_idx = '0; pc_val = '0;
    run_we = 1'b0; run_d = '0; run_vd = 1'b0;
    s_axis_tready = 1'b0;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (st_q)
      SIdle: begin
        s_axis_tready = !ov_q;
        if (s_axis_tvalid && !ov_q) begin
          case (action_e'(s_axis_tdata[1:0]))
            ActCreate: st_d = SCreate;
            ActSwitch: st_d = SSwPark;
            ActTick: begin
              loop_d = cq_cnt;
              st_d = SCwHead;
            end
            default: st_d = SOut;
          endcase
        end
      end
      SOut: begin
        // received byte
        if (out_free) begin
          bq_push = (bq_cnt != RCW'(RX_DEPTH));
          res_d = blank(KndPushed, bq_push ? StOk : StBufFull);
          ov_d = 1'b1;
          st_d = SIdle;
        end
      end
      SCreate: begin
        if (mode_q == ModeChild) begin
          if (run_pid < 0 || pcnt_q[tp_q[run_q]] >= max_thr_q) begin
            res_d = blank(KndCreate, StLimit);
            st_d = SCreateOut;
          end else begin
            proc_d = tp_q[run_q];
            st_d = SCreateMul;
          end
        end else if (mode_q == ModeFork) begin
          if (pq_cnt == '0) begin
            res_d = blank(KndCreate, StNoProc);
            st_d = SCreateOut;
          end else begin
            proc_d = pq_head;
            pq_pop = 1'b1;
            st_d = SCreateMul;
          end
        end else begin
          res_d = blank(KndCreate, StLimit);
          st_d = SCreateOut;
        end
        if (st_d == SCreateMul && fq_cnt == '0) begin
          // no free thread: a forked process goes to the tail
          pq_push = (mode_q == ModeFork);
          pq_din = pq_head;
          res_d = blank(KndCreate, StNoThread);
          st_d = SCreateOut;
        end else if (st_d == SCreateMul && rq_cnt == TCW'(THREADS)) begin
          pq_push = (mode_q == ModeFork);
          pq_din = pq_head;
          res_d = blank(KndCreate, StRdyFull);
          st_d = SCreateOut;
        end
      end
      SCreateMul: begin
        // product of the count before increment was registered at the last edge
        fq_pop = 1'b1;
        rq_push = 1'b1;
        rq_din = fq_head;
        tp_we = 1'b1; tp_idx = fq_head; tp_val = proc_q;
        pc_we = 1'b1; pc_idx = proc_q; pc_val = pcnt_q[proc_q] + 6'd1;
        res_d = blank(KndCreate, StOk);
        res_d.thread_id = 6'(signed'({1'b0, fq_head}));
        res_d.proc_id = 4'(signed'({1'b0, proc_q}));
        res_d.stack_pointer = sp;
        res_d.arg_pointer = ap;
        st_d = SCreateOut;
      end
      SCreateOut: begin
        if (out_free) begin
          ov_d = 1'b1;
          st_d = SIdle;
        end
      end
      SSwPark: begin
        old_d = run_valid_q ? 6'(signed'({1'b0, run_q})) : -6'sd1;
        oldp_d = run_valid_q ? run_pid : -4'sd1;
        if (run_valid_q) begin
          case (new_state_e'(act_q == ActTick ? NsReady : nst_q))
            NsReady: begin
              rq_push = 1'b1; rq_din = run_q;
            end
            NsFinished: begin
              if (run_pid >= 0) begin
                pc_we = 1'b1; pc_idx = tp_q[run_q];
                pc_val = (pcnt_q[tp_q[run_q]] != 0) ? pcnt_q[tp_q[run_q]] - 6'd1 : 6'd0;
                if (pc_val == 6'd0) begin
                  pq_push = 1'b1; pq_din = tp_q[run_q];
                end
              end
              fq_push = 1'b1; fq_din = run_q;
            end
            NsSleeping: begin
              cd_we = 1'b1; cd_addr = run_q; cd_wdata = {16'd0, ticks_q};
              sq_push = 1'b1; sq_din = run_q;
            end
            default: begin
              cd_we = 1'b1; cd_addr = run_q; cd_wdata = {16'd0, wait_tmo_q};
              cq_push = 1'b1; cq_din = run_q;
            end
          endcase
        end
        st_d = SSwPop;
      end
      SSwPop: begin
        if (out_free) begin
          res_d = blank(KndSwitch, StOk);
          res_d.old_thread_id = old_q;
          if (rq_cnt != '0) begin
            rq_pop = 1'b1;
            run_we = 1'b1; run_vd = 1'b1; run_d = rq_head;
            res_d.thread_id = 6'(signed'({1'b0, rq_head}));
            res_d.proc_id = tp_valid_q[rq_head] ?
                            4'(signed'({1'b0, tp_q[rq_head]})) : -4'sd1;
          end else begin
            run_we = 1'b1; run_vd = 1'b0;
          end
          res_d.context_change = (res_d.proc_id != oldp_q);
          ov_d = 1'b1;
          st_d = SIdle;
        end
      end
      SCwHead: begin
        if (loop_q == '0) begin
          loop_d = sq_cnt;
          st_d = SSlHead;
        end else begin
          cd_re = 1'b1; cd_addr = cq_head;
          tid_d = cq_head;
          cq_pop = 1'b1;
          st_d = SCwRead;
        end
      end
      SCwRead: begin
        // decrement through the shared write port
        cd_we = 1'b1; cd_addr = tid_q; cd_wdata = cd_val - 32'd1;
        st_d = SCwEval;
      end
      SCwEval: begin
        if (bq_cnt != '0 || (cd_val - 32'd1) == 32'd0 || (cd_val - 32'd1) >= 32'h8000_0000)
        begin
          if (out_free) begin
            res_d = blank(bq_cnt != '0 ? KndByte : KndTimeout, StOk);
            res_d.thread_id = 6'(signed'({1'b0, tid_q}));
            res_d.proc_id = tp_valid_q[tid_q] ? 4'(signed'({1'b0, tp_q[tid_q]})) : -4'sd1;
            res_d.data_byte = (bq_cnt != '0) ? bq_head : 8'd0;
            res_d.last = 1'b0;
            bq_pop = 1'b1;
            rq_push = 1'b1; rq_din = tid_q;
            ov_d = 1'b1;
            loop_d = loop_q - TCW'(1);
            st_d = SCwHead;
          end
        end else begin
          cq_push = 1'b1; cq_din = tid_q;
          loop_d = loop_q - TCW'(1);
          st_d = SCwHead;
        end
      end
      SSlHead: begin
        if (loop_q == '0) begin
          st_d = SSwPark;
        end else begin
          cd_re = 1'b1; cd_addr = sq_head;
          tid_d = sq_head;
          sq_pop = 1'b1;
          st_d = SSlRead;
        end
      end
      SSlRead: begin
        cd_we = 1'b1; cd_addr = tid_q; cd_wdata = cd_val - 32'd1;
        st_d = SSlEval;
      end
      SSlEval: begin
        if (cd_val == 32'd0 || cd_val[31]) begin
          rq_push = 1'b1; rq_din = tid_q;
        end else begin
          sq_push = 1'b1; sq_din = tid_q;
        end
        loop_d = loop_q - TCW'(1);
        st_d = SSlHead;
      end
      default: st_d = SIdle;
    endcase
  end

  // ---------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      loop_q <= '0;
      ov_q <= 1'b0;
      run_valid_q <= 1'b0;
      run_q <= '0;
      for (int i = 0; i < THREADS; i++) tp_valid_q[i] <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) pcnt_q[i] <= '0;
    end else begin
      st_q <= st_d;
      loop_q <= loop_d;
      ov_q <= ov_d;
      if (run_we) begin
        run_valid_q <= run_vd;
        run_q <= run_d;
      end
      if (tp_we) tp_valid_q[tp_idx] <= 1'b1;
      if (pc_we) pcnt_q[pc_idx] <= pc_val;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    proc_q <= proc_d;
    res_q <= res_d;
    old_q <= old_d;
    oldp_q <= oldp_d;
    if (tp_we) tp_q[tp_idx] <= tp_val;
    if (s_axis_tready && s_axis_tvalid) begin
      act_q   <= s_axis_tdata[1:0];
      mode_q  <= s_axis_tdata[3:2];
      args_q  <= s_axis_tdata[19:4];
      nst_q   <= s_axis_tdata[21:20];
      ticks_q <= s_axis_tdata[37:22];
      rxb_q   <= s_axis_tdata[45:38];
    end
  end

  // ---------------- output
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {1'b0, res_q.data_byte, res_q.arg_pointer, res_q.stack_pointer,
                          res_q.context_change, res_q.proc_id, res_q.old_thread_id,
                          res_q.thread_id, res_q.status, res_q.kind};
endmodule

FILE: rtl/rrts_checker.sv
// rrts_checker: port-level assertions on the scheduler
// depends on rrts_pkg; bound to round_robin_thread_scheduler_top

module rrts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rrts_pkg::OutW-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
  import rrts_pkg::*;

  // a held result beat stays unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // no new command while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("command taken with a result pending");

  // only tick results may be non-final
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tdata[2:0] == KndByte || m_axis_tdata[2:0] == KndTimeout))
    else $error("non-final beat of wrong kind");

  // a switch beat is always final
  a_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == KndSwitch |-> m_axis_tlast)
    else $error("switch beat without tlast");
endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast);

FILE: bench/tb_top.sv
// tb_top: self-checking regression for the round robin thread scheduler
// drives command beats, predicts every result beat with a local scheduler model
// and compares them field by field; depends on rtl/rrts_pkg.sv and the top level

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int NThr     = 32;
  localparam int NProc    = 8;
  localparam int RxCap    = 16;
  localparam int Align    = 8;
  localparam int MaxCycle = 1000000;
  localparam int Settle   = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [InW-1:0]    s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutW-1:0]   m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = RegStackTop;
  logic [CfgW-1:0]   cfg_data_i = '0;

  round_robin_thread_scheduler_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // one command beat
  typedef struct {
    action_e     act;
    logic [1:0]  mode;
    logic [15:0] args;
    new_state_e  nstate;
    logic [15:0] ticks;
    logic [7:0]  rx;
  } cmd_t;

  // scheduler model state
  int          thr_proc[NThr];
  logic [31:0] thr_count[NThr];
  int          ready_q[$];
  int          sleep_q[$];
  int          charwait_q[$];
  int          free_thr_q[$];
  int          free_proc_q[$];
  logic [7:0]  rx_q[$];
  int          proc_threads[NProc];
  int          running;
  logic [31:0] reg_stack_top;
  logic [31:0] reg_stack_bytes;
  logic [31:0] reg_wait_tmo;
  int          reg_max_thr;

  result_t     sched_expect_q[$];

  int errors = 0;
  int cycles = 0;
  int beats_in = 0;
  int beats_out = 0;
  int n_deliver = 0;
  int n_timeout = 0;
  int n_create_ok = 0;
  int n_create_err = 0;
  int burst_left = 0;
  int long_bursts = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("round_robin_thread_scheduler_top regression: fail");
      $finish;
    end
  end

  // receiver stall pattern, chosen at random from four modes
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_cnt % 8) < 5;
      default: m_axis_tready <= (stall_cnt % 16) < 2;
    endcase
  end

  function automatic bit le_zero(logic [31:0] v);
    return v == 32'd0 || v[31];
  endfunction

  function automatic void expect_beat(kind_e k, status_e st, int tid, int old, int pid,
                                      bit cc, logic [31:0] sp, logic [31:0] ap,
                                      logic [7:0] db, bit lst);
    result_t r;
    r.kind = k;
    r.status = st;
    r.thread_id = tid[5:0];
    r.old_thread_id = old[5:0];
    r.proc_id = pid[3:0];
    r.context_change = cc;
    r.stack_pointer = sp;
    r.arg_pointer = ap;
    r.data_byte = db;
    r.last = lst;
    sched_expect_q.push_back(r);
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < NThr; i++) begin
      thr_proc[i] = -1;
      thr_count[i] = '0;
    end
    ready_q.delete();
    sleep_q.delete();
    charwait_q.delete();
    free_thr_q.delete();
    free_proc_q.delete();
    rx_q.delete();
    for (int i = 0; i < NThr; i++) free_thr_q.push_back(i);
    for (int i = 0; i < NProc; i++) begin
      free_proc_q.push_back(i);
      proc_threads[i] = 0;
    end
    running = -1;
    reg_stack_top = 32'd0;
    reg_stack_bytes = 32'd16384;
    reg_wait_tmo = 32'd40;
    reg_max_thr = 4;
  endfunction

  // park the running thread and run the next ready one
  function automatic void model_switch(new_state_e ns, logic [15:0] ticks);
    int old, oldp, nxt, newp;
    old = running;
    oldp = -1;
    if (old >= 0) begin
      oldp = thr_proc[old];
      case (ns)
        NsReady: ready_q.push_back(old);
        NsFinished: begin
          if (oldp >= 0) begin
            if (proc_threads[oldp] > 0) proc_threads[oldp]--;
            if (proc_threads[oldp] == 0) free_proc_q.push_back(oldp);
          end
          free_thr_q.push_back(old);
        end
        NsSleeping: begin
          thr_count[old] = {16'd0, ticks};
          sleep_q.push_back(old);
        end
        default: begin
          thr_count[old] = reg_wait_tmo;
          charwait_q.push_back(old);
        end
      endcase
    end
    nxt = ready_q.size() ? ready_q.pop_front() : -1;
    newp = (nxt < 0) ? -1 : thr_proc[nxt];
    running = nxt;
    expect_beat(KndSwitch, StOk, nxt, old, newp, oldp != newp, '0, '0, '0, 1'b1);
  endfunction

  function automatic void model_create(logic [1:0] mode, logic [15:0] args);
    int p, t, pad;
    logic [31:0] base, ap;
    if (mode == ModeChild) begin
      p = (running < 0) ? -1 : thr_proc[running];
      if (p < 0 || proc_threads[p] >= reg_max_thr) begin
        expect_beat(KndCreate, StLimit, -1, -1, -1, 0, '0, '0, '0, 1'b1);
        n_create_err++;
        return;
      end
    end else if (mode == ModeFork) begin
      if (free_proc_q.size() == 0) begin
        expect_beat(KndCreate, StNoProc, -1, -1, -1, 0, '0, '0, '0, 1'b1);
        n_create_err++;
        return;
      end
      p = free_proc_q.pop_front();
    end else begin
      expect_beat(KndCreate, StLimit, -1, -1, -1, 0, '0, '0, '0, 1'b1);
      n_create_err++;
      return;
    end
    if (free_thr_q.size() == 0) begin
      if (mode == ModeFork) free_proc_q.push_back(p);
      expect_beat(KndCreate, StNoThread, -1, -1, -1, 0, '0, '0, '0, 1'b1);
      n_create_err++;
      return;
    end
    t = free_thr_q.pop_front();
    if (ready_q.size() >= NThr) begin
      free_thr_q.push_back(t);
      if (mode == ModeFork) free_proc_q.push_back(p);
      expect_beat(KndCreate, StRdyFull, -1, -1, -1, 0, '0, '0, '0, 1'b1);
      n_create_err++;
      return;
    end
    ready_q.push_back(t);
    base = reg_stack_top - proc_threads[p] * reg_stack_bytes;
    thr_proc[t] = p;
    proc_threads[p] = (proc_threads[p] + 1) & 63;
    ap = base - {16'd0, args};
    pad = (args % Align == 0) ? 0 : Align - (args % Align);
    expect_beat(KndCreate, StOk, t, -1, p, 0, ap - pad, ap, '0, 1'b1);
    n_create_ok++;
  endfunction

  // timer tick: char waiters, then sleepers, then a ready switch
  function automatic void model_tick();
    int n, id;
    logic [31:0] prev;
    n = charwait_q.size();
    for (int i = 0; i < n; i++) begin
      id = charwait_q.pop_front();
      thr_count[id] = thr_count[id] - 1;
      if (rx_q.size() > 0) begin
        ready_q.push_back(id);
        expect_beat(KndByte, StOk, id, -1, thr_proc[id], 0, '0, '0, rx_q.pop_front(), 1'b0);
        n_deliver++;
      end else if (le_zero(thr_count[id])) begin
        ready_q.push_back(id);
        expect_beat(KndTimeout, StOk, id, -1, thr_proc[id], 0, '0, '0, '0, 1'b0);
        n_timeout++;
      end else begin
        charwait_q.push_back(id);
      end
    end
    n = sleep_q.size();
    for (int i = 0; i < n; i++) begin
      id = sleep_q.pop_front();
      prev = thr_count[id];
      thr_count[id] = prev - 1;
      if (le_zero(prev)) ready_q.push_back(id);
      else sleep_q.push_back(id);
    end
    model_switch(NsReady, 16'd0);
  endfunction

  function automatic void model_step(cmd_t c);
    case (c.act)
      ActCreate: model_create(c.mode, c.args);
      ActSwitch: model_switch(c.nstate, c.ticks);
      ActTick:   model_tick();
      default: begin
        if (rx_q.size() < RxCap) begin
          rx_q.push_back(c.rx);
          expect_beat(KndPushed, StOk, -1, -1, -1, 0, '0, '0, '0, 1'b1);
        end else begin
          expect_beat(KndPushed, StBufFull, -1, -1, -1, 0, '0, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata[94:0]};
      beats_out <= beats_out + 1;
      if (sched_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = sched_expect_q.pop_front();
        if (got.kind !== want.kind)
          $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.thread_id !== want.thread_id)
          $display("%0t: thread_id exp %0d got %0d", $time, want.thread_id, got.thread_id);
        if (got.old_thread_id !== want.old_thread_id)
          $display("%0t: old_thread_id exp %0d got %0d", $time, want.old_thread_id,
                   got.old_thread_id);
        if (got.proc_id !== want.proc_id)
          $display("%0t: proc_id exp %0d got %0d", $time, want.proc_id,
                   got.proc_id);
        if (got.context_change !== want.context_change)
          $display("%0t: context_change exp %0d got %0d", $time, want.context_change,
                   got.context_change);
        if (got.stack_pointer !== want.stack_pointer)
          $display("%0t: stack_pointer exp %h got %h", $time, want.stack_pointer,
                   got.stack_pointer);
        if (got.arg_pointer !== want.arg_pointer)
          $display("%0t: arg_pointer exp %h got %h", $time, want.arg_pointer,
                   got.arg_pointer);
        if (got.data_byte !== want.data_byte)
          $display("%0t: data_byte exp %h got %h", $time, want.data_byte, got.data_byte);
        if (got.last !== want.last)
          $display("%0t: tlast exp %0d got %0d", $time, want.last, got.last);
        if (got !== want) errors <= errors + 1;
      end
    end
  end

  // send one command beat, with bursts and random gaps in between
  task automatic send_cmd(cmd_t c);
    if (burst_left == 0) begin
      if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = long_bursts ? 60 : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, c.rx, c.ticks, c.nstate, c.args, c.mode, c.act};
    do @(posedge clk_i); while (!s_axis_tready);
    model_step(c);
    beats_in++;
    burst_left--;
  endtask

  // hold the sender until every expected result has arrived, then let it settle
  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sched_expect_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // write all four registers; only called with the block idle
  task automatic write_regs(logic [31:0] top, logic [23:0] sbytes, logic [15:0] tmo,
                            logic [5:0] mx);
    logic [31:0] vals[4];
    vals = '{top, {8'd0, sbytes}, {16'd0, tmo}, {26'd0, mx}};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[1:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    reg_stack_top = top;
    reg_stack_bytes = {8'd0, sbytes};
    reg_wait_tmo = {16'd0, tmo};
    reg_max_thr = mx;
  endtask

  function automatic cmd_t mk(action_e a, logic [1:0] m, logic [15:0] args,
                              new_state_e ns, logic [15:0] tk, logic [7:0] rx);
    cmd_t c;
    c.act = a;
    c.mode = m;
    c.args = args;
    c.nstate = ns;
    c.ticks = tk;
    c.rx = rx;
    return c;
  endfunction

  // random command, biased toward sequences that keep threads moving
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.mode = 2'($urandom_range(0, 9) < 8 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.args = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 40));
    c.nstate = new_state_e'($urandom_range(0, 3));
    c.ticks = 16'($urandom_range(0, 65535));
    c.rx = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 30) c.act = ActCreate;
    else if (r < 60) c.act = ActSwitch;
    else if (r < 85) c.act = ActTick;
    else c.act = ActPush;
    // short sleeps mostly, so sleepers come back within the run
    if (c.act == ActSwitch && c.nstate == NsSleeping && $urandom_range(0, 19) != 0)
      c.ticks = 16'($urandom_range(0, 6));
    return c;
  endfunction

  // directed: corner cases of create, switch, tick and push
  task automatic test_directed();
    send_cmd(mk(ActCreate, ModeChild, 16'd8, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, 2'd2, 16'hffff, NsReady, 16'hffff, 8'hff));
    send_cmd(mk(ActCreate, 2'd3, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsSleeping, 16'hffff, 8'd0));
    send_cmd(mk(ActTick, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeFork, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeFork, 16'hffff, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeChild, 16'd7, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeChild, 16'd1, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsSleeping, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsWaitChar, 16'd0, 8'd0));
    send_cmd(mk(ActPush, 2'd0, 16'd0, NsReady, 16'd0, 8'hff));
    send_cmd(mk(ActPush, 2'd0, 16'd0, NsReady, 16'd0, 8'h00));
    send_cmd(mk(ActTick, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsSleeping, 16'h8000, 8'd0));
    send_cmd(mk(ActTick, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsFinished, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsFinished, 16'd0, 8'd0));
    send_cmd(mk(ActTick, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    wait_drained();
  endtask

  // char-wait timeout under the shortest timeout
  task automatic test_wait_timeout();
    write_regs(32'hffff_ffff, 24'hff_ffff, 16'd1, 6'd32);
    send_cmd(mk(ActCreate, ModeFork, 16'd5, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeChild, 16'd3, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsWaitChar, 16'd0, 8'd0));
    send_cmd(mk(ActTick, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActTick, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    wait_drained();
  endtask

  // use up threads and processes, then overfill the receive buffer
  task automatic test_exhaustion();
    int guard;
    guard = 0;
    while (free_proc_q.size() != 0 && guard < 12) begin
      send_cmd(mk(ActCreate, ModeFork, 16'($urandom_range(0, 65535)), NsReady, 16'd0,
                  8'd0));
      guard++;
    end
    send_cmd(mk(ActCreate, ModeFork, 16'd0, NsReady, 16'd0, 8'd0));
    if (running < 0) send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsReady, 16'd0, 8'd0));
    guard = 0;
    while (free_thr_q.size() != 0 && guard < 40) begin
      send_cmd(mk(ActCreate, ModeChild, 16'($urandom_range(0, 65535)), NsReady, 16'd0,
                  8'd0));
      guard++;
    end
    send_cmd(mk(ActCreate, ModeChild, 16'd2, NsReady, 16'd0, 8'd0));
    // free one lone thread's process so a fork finds a process but no thread
    send_cmd(mk(ActSwitch, 2'd0, 16'd0, NsFinished, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeChild, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeFork, 16'd0, NsReady, 16'd0, 8'd0));
    send_cmd(mk(ActCreate, ModeFork, 16'd0, NsReady, 16'd0, 8'd0));
    for (int i = 0; i < RxCap + 2; i++)
      send_cmd(mk(ActPush, 2'd0, 16'd0, NsReady, 16'd0, 8'($urandom_range(0, 255))));
    wait_drained();
  endtask

  // random traffic under one register setting
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      if (i % 40 == 0) long_bursts = ($urandom_range(0, 3) == 0);
      send_cmd(rand_cmd());
    end
    long_bursts = 0;
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100);
    test_wait_timeout();
    test_exhaustion();
    test_random(90);
    write_regs($urandom, 24'($urandom_range(0, 24'hff_ffff)), 16'd3, 6'd1);
    test_random(90);
    write_regs(32'h1234_5678, 24'd0, 16'hffff, 6'd2);
    test_random(60);
    write_regs(32'h8000_0000, 24'd4096, 16'd2, 6'd32);
    test_random(90);
    $display("covered %0d command beats, %0d result beats: %0d creates ok, %0d refused",
             beats_in, beats_out, n_create_ok, n_create_err);
    $display("char waits: %0d bytes delivered, %0d timeouts", n_deliver, n_timeout);
    if (errors == 0 && sched_expect_q.size() == 0) begin
      $display("round_robin_thread_scheduler_top regression: pass");
    end else begin
      $display("round_robin_thread_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
